// File: src/wcsp_pkg.sv
package wcsp_pkg;

   // One file byte as it arrives.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
   } req_type;

   // One result, either a sample byte or the final status.
   typedef struct packed {
      logic        kind;
      logic [7:0]  sample_byte;
      logic [1:0]  status;
      logic [1:0]  layout;
      logic [31:0] sample_rate;
      logic [15:0] channel_count;
      logic [15:0] sample_bits;
      logic [30:0] data_length;
      logic        last;
   } rsp_type;

   // What the parser leaves for the output side for one accepted byte.
   typedef struct packed {
      logic       has_sample;
      logic [7:0] sample_byte;
      logic       has_status;
      logic [1:0] status;
   } event_type;

   // Format values captured by the parser; frozen once the status is queued.
   typedef struct packed {
      logic [31:0] sample_rate;
      logic [15:0] channel_count;
      logic [15:0] sample_bits;
      logic [30:0] data_length;
   } held_type;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [0:0] KIND_SAMPLE = 1'b0;
   localparam logic [0:0] KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_MISSING     = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
   localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd3;

   localparam logic [1:0] LAYOUT_MONO8    = 2'd0;
   localparam logic [1:0] LAYOUT_MONO16   = 2'd1;
   localparam logic [1:0] LAYOUT_STEREO8  = 2'd2;
   localparam logic [1:0] LAYOUT_STEREO16 = 2'd3;

   localparam logic [31:0] TAG_FMT      = 32'h666D7420;
   localparam logic [31:0] TAG_DATA     = 32'h64617461;
   localparam logic [31:0] HEADER_BYTES = 32'd12;
   localparam logic [31:0] TAG_BYTES    = 32'd4;
   localparam logic [31:0] FMT_FIXED    = 32'd16;

endpackage

// File: src/wcsp_front.sv
module wcsp_front
   import wcsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   input  req_type   req_data,
   input  logic      queue_full,
   output logic      queue_push,
   output event_type queue_data,
   output held_type  held
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_TAG    = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_FMT    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] length_ff, length_in;
   logic        format_seen_ff, format_seen_in;
   logic        samples_seen_ff, samples_seen_in;
   logic [15:0] channels_ff, channels_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;
   logic [30:0] data_length_ff, data_length_in;
   logic        finished_ff, finished_in;

   logic        accept;
   logic [31:0] count_inc;
   logic [31:0] length_new;
   logic        chunk_done;
   logic [7:0]  b;

   assign accept    = req_push && !queue_full;
   assign b         = req_data.byte_value;
   assign count_inc = count_ff + 32'd1;

   always_comb begin
      length_new = length_ff;
      for (int i = 0; i < 4; i++) begin
         if (count_ff[1:0] == 2'(i)) begin
            length_new[8*i +: 8] = length_ff[8*i +: 8] | b;
         end
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      tag_in          = tag_ff;
      length_in       = length_ff;
      format_seen_in  = format_seen_ff;
      samples_seen_in = samples_seen_ff;
      channels_in     = channels_ff;
      bits_in         = bits_ff;
      rate_in         = rate_ff;
      data_length_in  = data_length_ff;
      finished_in     = finished_ff;
      chunk_done      = 1'b0;
      queue_data      = '{has_sample: 1'b0, sample_byte: b, has_status: 1'b0,
                          status: STATUS_OK};

      if (accept && !finished_ff) begin
         unique case (phase_ff)
            PH_HEADER: begin
               count_in = count_inc;
               if (count_inc >= HEADER_BYTES) begin
                  phase_in = PH_TAG;
                  count_in = '0;
                  tag_in   = '0;
               end
            end
            PH_TAG: begin
               tag_in   = {tag_ff[23:0], b};
               count_in = count_inc;
               if (count_inc >= TAG_BYTES) begin
                  phase_in  = PH_LEN;
                  count_in  = '0;
                  length_in = '0;
               end
            end
            PH_LEN: begin
               length_in = length_new;
               count_in  = count_inc;
               if (count_inc >= TAG_BYTES) begin
                  count_in = '0;
                  if (length_new[31]) begin
                     queue_data.has_status = 1'b1;
                     queue_data.status     = STATUS_BAD_LENGTH;
                     finished_in           = 1'b1;
                  end else if (tag_ff == TAG_FMT) begin
                     format_seen_in = 1'b1;
                     phase_in       = PH_FMT;
                  end else if (tag_ff == TAG_DATA) begin
                     samples_seen_in = 1'b1;
                     data_length_in  = length_new[30:0];
                     if (length_new == '0) chunk_done = 1'b1;
                     else phase_in = PH_DATA;
                  end else begin
                     if (length_new == '0) chunk_done = 1'b1;
                     else phase_in = PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               unique case (count_ff[3:0])
                  4'd2:  channels_in[7:0]   = b;
                  4'd3:  channels_in[15:8]  = b;
                  4'd4:  rate_in[7:0]       = b;
                  4'd5:  rate_in[15:8]      = b;
                  4'd6:  rate_in[23:16]     = b;
                  4'd7:  rate_in[31:24]     = b;
                  4'd14: bits_in[7:0]       = b;
                  4'd15: bits_in[15:8]      = b;
                  default: ;
               endcase
               count_in = count_inc;
               if (count_inc >= FMT_FIXED) begin
                  if (length_ff > FMT_FIXED) begin
                     length_in = length_ff - FMT_FIXED;
                     count_in  = '0;
                     phase_in  = PH_SKIP;
                  end else begin
                     chunk_done = 1'b1;
                  end
               end
            end
            PH_DATA: begin
               queue_data.has_sample = 1'b1;
               count_in              = count_inc;
               if (count_inc >= length_ff) chunk_done = 1'b1;
            end
            PH_SKIP: begin
               count_in = count_inc;
               if (count_inc >= length_ff) chunk_done = 1'b1;
            end
            default: ;
         endcase

         if (chunk_done) begin
            if (format_seen_in && samples_seen_in) begin
               queue_data.has_status = 1'b1;
               queue_data.status     = STATUS_OK;
               finished_in           = 1'b1;
            end else begin
               phase_in = PH_TAG;
               count_in = '0;
               tag_in   = '0;
            end
         end

         // The final byte of the file closes parsing if nothing else did.
         if (req_data.end_of_file && !finished_in) begin
            queue_data.has_status = 1'b1;
            queue_data.status     = (format_seen_in && samples_seen_in) ?
                                    STATUS_OK : STATUS_MISSING;
            finished_in           = 1'b1;
         end
      end

      queue_push = accept && (queue_data.has_sample || queue_data.has_status);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         count_ff        <= '0;
         tag_ff          <= '0;
         length_ff       <= '0;
         format_seen_ff  <= 1'b0;
         samples_seen_ff <= 1'b0;
         channels_ff     <= '0;
         bits_ff         <= '0;
         rate_ff         <= '0;
         data_length_ff  <= '0;
         finished_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         tag_ff          <= tag_in;
         length_ff       <= length_in;
         format_seen_ff  <= format_seen_in;
         samples_seen_ff <= samples_seen_in;
         channels_ff     <= channels_in;
         bits_ff         <= bits_in;
         rate_ff         <= rate_in;
         data_length_ff  <= data_length_in;
         finished_ff     <= finished_in;
      end
   end

   assign held = '{sample_rate: rate_ff, channel_count: channels_ff,
                   sample_bits: bits_ff, data_length: data_length_ff};

   a_no_beat_after_status: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !queue_push)
      else $error("parser queued a beat after the final status");

   // The byte that queues the status may still write a held field at that same edge.
   a_status_freezes: assert property (@(posedge clock) disable iff (reset)
      (queue_push && queue_data.has_status) |=> finished_ff ##1 $stable(held))
      else $error("held format values changed after the status was queued");

endmodule

// File: src/wcsp_queue.sv
module wcsp_queue
   import wcsp_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   output logic      full,
   input  logic      pop,
   output event_type pop_data,
   output logic      empty
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   event_type entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CountW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CountW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CountW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Depth))
      else $error("queue fill count above its depth");

endmodule

// File: src/wcsp_back.sv
module wcsp_back
   import wcsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      queue_empty,
   input  event_type queue_data,
   output logic      queue_pop,
   input  held_type  held,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   function automatic rsp_type make_status(logic [1:0] code, held_type h);
      rsp_type    r;
      logic [1:0] st;
      logic [1:0] lay;
      st  = code;
      lay = LAYOUT_MONO8;
      if (code == STATUS_OK) begin
         priority if (h.channel_count == 16'd1 && h.sample_bits == 16'd8)
            lay = LAYOUT_MONO8;
         else if (h.channel_count == 16'd1 && h.sample_bits == 16'd16)
            lay = LAYOUT_MONO16;
         else if (h.channel_count == 16'd2 && h.sample_bits == 16'd8)
            lay = LAYOUT_STEREO8;
         else if (h.channel_count == 16'd2 && h.sample_bits == 16'd16)
            lay = LAYOUT_STEREO16;
         else
            st = STATUS_UNSUPPORTED;
      end
      r = '{kind: KIND_STATUS, sample_byte: 8'd0, status: st, layout: lay,
            sample_rate: h.sample_rate, channel_count: h.channel_count,
            sample_bits: h.sample_bits, data_length: h.data_length, last: 1'b1};
      return r;
   endfunction

   function automatic rsp_type make_sample(logic [7:0] value);
      rsp_type r;
      r = '0;
      r.kind        = KIND_SAMPLE;
      r.sample_byte = value;
      return r;
   endfunction

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       pend_ff, pend_in;
   logic [1:0] pend_code_ff, pend_code_in;
   logic       load_ok;

   assign load_ok = !out_valid_ff || rsp_pop;

   // A beat carrying both a sample and the status shows the sample first and
   // keeps the status pending for the following slot.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      pend_in      = pend_ff;
      pend_code_in = pend_code_ff;
      queue_pop    = 1'b0;
      if (load_ok) begin
         if (pend_ff) begin
            out_in       = make_status(pend_code_ff, held);
            out_valid_in = 1'b1;
            pend_in      = 1'b0;
         end else if (!queue_empty) begin
            queue_pop    = 1'b1;
            out_valid_in = 1'b1;
            if (queue_data.has_sample) begin
               out_in       = make_sample(queue_data.sample_byte);
               pend_in      = queue_data.has_status;
               pend_code_in = queue_data.status;
            end else begin
               out_in = make_status(queue_data.status, held);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      pend_code_ff <= pend_code_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_pending_behind_sample: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (out_valid_ff && out_ff.kind == KIND_SAMPLE))
      else $error("pending status without a sample ahead of it");

   a_no_pop_while_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !queue_pop)
      else $error("queue popped while a status was still pending");

endmodule

// File: src/wav_chunk_stream_parser.sv
// Path: an accepted byte's event goes into the event queue, then into the output register
// on rsp_data. Throughput: one byte per cycle while req_full is low; bytes without a result
// (header, tags, lengths, skipped chunks) are taken at that rate too, and a byte giving both
// a sample and the status sends the sample, then the status, via the single output register.
// Reset (synchronous, active high) returns the parser to the RIFF header and empties the
// event queue and the output register.
module wav_chunk_stream_parser
   import wcsp_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic      q_push;
   event_type q_push_data;
   logic      q_full;
   logic      q_pop;
   event_type q_pop_data;
   logic      q_empty;
   held_type  held;

   assign req_full = q_full;

   wcsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (q_full),
      .queue_push (q_push),
      .queue_data (q_push_data),
      .held       (held)
   );

   wcsp_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   wcsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_data  (q_pop_data),
      .queue_pop   (q_pop),
      .held        (held),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule
